/* sv/bst_pkg.sv */
// Shared types and constants for the array-held binary search tree.
package bst_pkg;

  localparam int TreeLevels    = 10;
  localparam int KeyW          = 32;
  localparam int SlotW         = TreeLevels;
  localparam int CountW        = TreeLevels;
  localparam int PosW          = TreeLevels;
  localparam int SlotCount     = 2 ** TreeLevels - 1;
  localparam int MaxLevelSlots = 2 ** (TreeLevels - 1);
  localparam int ClrW          = TreeLevels - 1;

  typedef logic signed [KeyW-1:0] key_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Walk token handed from one level to the next. pos is slot + 1, so its
  // low bits are the index within the level and a child is {pos, greater}.
  typedef struct packed {
    logic                valid;
    cmd_e                cmd;
    key_t                key;
    logic                done;
    status_e             status;
    logic [SlotW-1:0]    slot;
    logic [PosW-1:0]     pos;
  } tok_t;

  typedef struct packed {
    logic vld;
    key_t key;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [PosW-1:0] pos;
    entry_t          data;
  } wr_req_t;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } result_t;

endpackage

/* sv/bst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bst_ram #(
  parameter int Depth = 2,
  parameter int Width = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/bst_cell.sv */
// One tree level: compares the walking key with the entry read for it.
module bst_cell import bst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  tok_t    tok_i,
  input  entry_t  rd_data_i,
  output tok_t    tok_o,
  output wr_req_t wr_o
);

  tok_t tok_q;
  logic gt;
  logic [SlotW-1:0] here_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign gt        = $signed(tok_q.key) > $signed(rd_data_i.key);
  assign here_slot = SlotW'(tok_q.pos - PosW'(1));

  always_comb begin
    tok_o         = tok_q;
    wr_o.en       = 1'b0;
    wr_o.pos      = tok_q.pos;
    wr_o.data.vld = 1'b1;
    wr_o.data.key = tok_q.key;
    if (tok_q.valid && !tok_q.done) begin
      if (!rd_data_i.vld) begin
        // empty slot ends the walk
        tok_o.done = 1'b1;
        if (tok_q.cmd == CMD_INSERT) begin
          wr_o.en      = 1'b1;
          tok_o.status = ST_INSERTED;
          tok_o.slot   = here_slot;
        end else begin
          tok_o.status = ST_NOT_FOUND;
          tok_o.slot   = '0;
        end
      end else if (tok_q.key == rd_data_i.key) begin
        tok_o.done   = 1'b1;
        tok_o.status = (tok_q.cmd == CMD_INSERT) ? ST_PRESENT : ST_FOUND;
        tok_o.slot   = here_slot;
      end else begin
        tok_o.pos = {tok_q.pos[PosW-2:0], gt};
      end
    end
  end

endmodule

/* sv/array_binary_search_tree.sv */
// Array-held binary search tree: insert and lookup of signed 32-bit keys.
//
// Input channel (in_valid_i / in_ready_o) takes a command (insert or look up)
// and a key; output channel (out_valid_o / out_ready_i) returns a status, the
// slot of the key and the number of keys stored after the transaction.
// The tree is a chain of ten level cells, each with its own RAM holding that
// level's slots. A transaction walks the chain one level per cycle: the
// read data of one level is compared and the child address goes straight to the
// next level's RAM. A new transaction is accepted only after the last one
// has left the level chain; only one transaction is in the tree at a time.
// After reset the block sweeps every level RAM to clear the valid marks;
// in_ready_o stays low until the sweep is done.
// If the receiver stalls, the finished result waits in the output register
// and a new transaction is still accepted; a second result waits in a
// holding register and the next acceptance waits until it has moved on.
module array_binary_search_tree import bst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic signed [KeyW-1:0]  key_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [SlotW-1:0]        slot_o,
  output logic [CountW-1:0]       stored_count_o
);

  tok_t tok [TreeLevels+1];

  logic            accept;
  logic            clearing_q, clearing_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic            busy_q, busy_d;
  logic [CountW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  logic            pend_valid_q, pend_valid_d;
  result_t         out_q, out_d, pend_q, pend_d, fin_res;
  logic            out_free;
  tok_t            fin;

  assign in_ready_o = !busy_q && !clearing_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = accept;
    tok[0].cmd    = cmd_e'(command_i);
    tok[0].key    = key_i;
    tok[0].status = ST_NOT_FOUND;
    tok[0].pos    = PosW'(1);
  end

  for (genvar l = 0; l < TreeLevels; l++) begin : g_level
    localparam int Depth = 2 ** l;
    localparam int AW    = (l > 0) ? l : 1;

    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        rd_data, wr_data;
    wr_req_t       wr;
    logic          wr_en;

    if (l == 0) begin : g_root
      assign rd_addr = '0;
      assign wr_addr = '0;
    end else begin : g_node
      assign rd_addr = tok[l].pos[AW-1:0];
      assign wr_addr = clearing_q ? clr_q[AW-1:0] : wr.pos[AW-1:0];
    end

    assign wr_en   = clearing_q || wr.en;
    assign wr_data = clearing_q ? entry_t'('0) : wr.data;

    bst_ram #(
      .Depth (Depth),
      .Width ($bits(entry_t))
    ) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en),
      .wr_addr_i (wr_addr),
      .wr_data_i (wr_data),
      .rd_addr_i (rd_addr),
      .rd_data_o (rd_data)
    );

    bst_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[l]),
      .rd_data_i (rd_data),
      .tok_o     (tok[l+1]),
      .wr_o      (wr)
    );
  end

  // A walk that is still open after the last level ran past the store.
  assign fin = tok[TreeLevels];

  always_comb begin
    if (fin.done) begin
      fin_res.status = fin.status;
      fin_res.slot   = fin.slot;
    end else begin
      fin_res.status = (fin.cmd == CMD_INSERT) ? ST_NO_ROOM : ST_NOT_FOUND;
      fin_res.slot   = '0;
    end
    count_d = count_q;
    if (fin.valid && fin_res.status == ST_INSERTED) begin
      count_d = count_q + CountW'(1);
    end
    fin_res.count = count_d;
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    busy_d       = busy_q || accept;
    if (pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
      busy_d       = 1'b0;
    end else if (fin.valid && out_free) begin
      out_valid_d = 1'b1;
      out_d       = fin_res;
      busy_d      = 1'b0;
    end else if (fin.valid) begin
      pend_valid_d = 1'b1;
      pend_d       = fin_res;
    end
  end

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_d = clr_q + ClrW'(1);
      if (clr_q == ClrW'(MaxLevelSlots - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q   <= 1'b1;
      clr_q        <= '0;
      busy_q       <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      clearing_q   <= clearing_d;
      clr_q        <= clr_d;
      busy_q       <= busy_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign slot_o         = out_q.slot;
  assign stored_count_o = out_q.count;

endmodule

/* tb/bst_walk_checker.sv */
// Watches both channels of the tree block, predicts each outcome and checks it.
`timescale 1ns / 100ps

module bst_walk_checker import bst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic              command_i,
  input  key_t              key_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [2:0]        status_o,
  input  logic [SlotW-1:0]  slot_o,
  input  logic [CountW-1:0] stored_count_o,
  output int                errors_o,
  output int                pending_o
);

  key_t        tree_key  [SlotCount];
  logic        tree_used [SlotCount];
  int unsigned key_total;
  result_t     awaited_results [$];
  int          error_cnt;

  // Walk the key's path down the implicit array and update the copy of the tree.
  function automatic result_t predict_outcome(cmd_e cmd, key_t k);
    int unsigned j;
    logic        hit;
    logic        empty;
    result_t     res;
    j     = 0;
    hit   = 1'b0;
    empty = 1'b0;
    for (int lvl = 0; lvl < TreeLevels; lvl++) begin
      if (j >= SlotCount) break;
      if (!tree_used[j]) begin
        empty = 1'b1;
        break;
      end
      if (k == tree_key[j]) begin
        hit = 1'b1;
        break;
      end
      j = (k < tree_key[j]) ? 2 * j + 1 : 2 * j + 2;
    end
    res.slot = '0;
    if (cmd == CMD_INSERT) begin
      if (empty) begin
        tree_key[j]  = k;
        tree_used[j] = 1'b1;
        key_total++;
        res.status = ST_INSERTED;
        res.slot   = j[SlotW-1:0];
      end else if (hit) begin
        res.status = ST_PRESENT;
        res.slot   = j[SlotW-1:0];
      end else begin
        res.status = ST_NO_ROOM;
      end
    end else if (hit) begin
      res.status = ST_FOUND;
      res.slot   = j[SlotW-1:0];
    end else begin
      res.status = ST_NOT_FOUND;
    end
    res.count = key_total[CountW-1:0];
    return res;
  endfunction

  function automatic int check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      foreach (tree_used[i]) tree_used[i] = 1'b0;
      key_total = 0;
      awaited_results.delete();
      error_cnt = 0;
    end else begin
      // a result can never belong to the transaction accepted at the same edge
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited, status %0d slot %0d count %0d",
                   $time, status_o, slot_o, stored_count_o);
          error_cnt++;
        end else begin
          want = awaited_results.pop_front();
          error_cnt += check_field("status", want.status, status_o);
          error_cnt += check_field("slot", want.slot, slot_o);
          error_cnt += check_field("stored_count", want.count, stored_count_o);
        end
      end
      if (in_valid_i && in_ready_o)
        awaited_results.push_back(predict_outcome(cmd_e'(command_i), key_i));
    end
    errors_o  <= error_cnt;
    pending_o <= awaited_results.size();
  end

endmodule

/* tb/array_binary_search_tree_test.sv */
// Top of the tree block's testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module array_binary_search_tree_test import bst_pkg::*;;

  localparam int RandomItems = 400;
  localparam int CycleLimit  = 200000;
  localparam int IdlePct     = 13;
  localparam int DrainCycles = 30;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              command_i      = 1'b0;
  key_t              key_i          = '0;
  logic              out_ready_i    = 1'b0;
  logic              quiet_q        = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [2:0]        status_o;
  logic [SlotW-1:0]  slot_o;
  logic [CountW-1:0] stored_count_o;
  int                error_total;
  int                awaited_total;
  int                cycle_cnt      = 0;
  key_t              inserted_keys [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  array_binary_search_tree dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .stored_count_o (stored_count_o)
  );

  bst_walk_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .stored_count_o (stored_count_o),
    .errors_o       (error_total),
    .pending_o      (awaited_total)
  );

  always @(posedge clk_i) begin
    out_ready_i <= quiet_q || ($urandom_range(99) >= IdlePct);
  end

  // Offers one transaction and returns at the edge where it is taken.
  task automatic issue(cmd_e cmd, key_t k);
    while (!quiet_q && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (cmd == CMD_INSERT) inserted_keys.push_back(k);
  endtask

  function automatic key_t known_key();
    if (inserted_keys.size() == 0) return key_t'($urandom());
    return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
  endfunction

  function automatic key_t edge_key();
    case ($urandom_range(3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("array_binary_search_tree_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int   sent;
    int   pick;
    int   run_len;
    int   step;
    logic rising;
    key_t k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty tree, duplicate, extremes, then one path driven to full depth
    issue(CMD_LOOKUP, 32'sd0);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_LOOKUP, 32'sd0);
    issue(CMD_INSERT, 32'sh8000_0000);
    issue(CMD_INSERT, 32'sh7fff_ffff);
    issue(CMD_INSERT, -32'sd1);
    issue(CMD_INSERT, 32'sd1);
    issue(CMD_LOOKUP, 32'sh8000_0000);
    issue(CMD_LOOKUP, 32'sh7fff_ffff);
    issue(CMD_LOOKUP, 32'sd5);
    // 1 sits at level 2; 2..8 take levels 3..9 and 9 falls off the bottom
    for (int v = 2; v <= 9; v++) issue(CMD_INSERT, key_t'(v));
    issue(CMD_INSERT, 32'sd9);
    issue(CMD_LOOKUP, 32'sd9);
    issue(CMD_LOOKUP, 32'sd8);

    sent = 0;
    while (sent < RandomItems) begin
      quiet_q <= (sent >= 150 && sent < 250);
      pick = $urandom_range(99);
      if (pick < 28) begin
        issue(CMD_INSERT, key_t'($urandom()));
        sent++;
      end else if (pick < 40) begin
        issue(CMD_INSERT, key_t'(int'($urandom_range(16)) - 8));
        sent++;
      end else if (pick < 55) begin
        issue(CMD_LOOKUP, known_key());
        sent++;
      end else if (pick < 63) begin
        issue(CMD_LOOKUP, key_t'($urandom()));
        sent++;
      end else if (pick < 71) begin
        issue(CMD_INSERT, known_key());
        sent++;
      end else if (pick < 75) begin
        issue(cmd_e'($urandom_range(1)), edge_key());
        sent++;
      end else if (pick < 87) begin
        // sorted run: grows one branch, which can run the walk out of levels
        run_len = $urandom_range(14, 6);
        step    = $urandom_range(1000, 1);
        rising  = 1'($urandom_range(1));
        k       = ($urandom_range(3) == 0) ? edge_key() : key_t'($urandom());
        for (int r = 0; r < run_len; r++) begin
          issue(CMD_INSERT, k);
          k = rising ? k + step : k - step;
        end
        issue(CMD_LOOKUP, k);
        issue(CMD_LOOKUP, known_key());
        sent += run_len + 2;
      end else begin
        issue(CMD_LOOKUP, key_t'(int'($urandom_range(16)) - 8));
        sent++;
      end
    end
    in_valid_i <= 1'b0;
    quiet_q    <= 1'b0;

    @(posedge clk_i);
    while (awaited_total != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_total == 0) begin
      $display("array_binary_search_tree_test: done, clean");
    end else begin
      $display("array_binary_search_tree_test: done, errors");
    end
    $finish;
  end

endmodule
